@@ rtl/lsp_pkg.sv @@
`default_nettype none

package lsp_pkg;

   typedef struct packed {
      logic [7:0] cover_byte;
      logic       start_of_image;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

   localparam logic [1:0] KindExt      = 2'd0;
   localparam logic [1:0] KindPayload  = 2'd1;
   localparam logic [1:0] KindMismatch = 2'd2;
   localparam logic [1:0] KindEmpty    = 2'd3;

   localparam logic [1:0] CsrMagic = 2'd0;
   localparam logic [1:0] CsrSkip  = 2'd1;

   localparam logic [15:0] MagicReset = 16'd9002;
   localparam logic [7:0]  SkipReset  = 8'd54;

   localparam int QueueDepth = 2;

endpackage

`default_nettype wire

@@ rtl/lsp_chan_if.sv @@
`default_nettype none

interface lsp_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/lsp_front.sv @@
`default_nettype none

module lsp_front #(
   parameter int EXT_CHARS = 4,
   parameter int SIZE_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire lsp_pkg::req_type req,
   input  wire logic [15:0]      magic_value,
   input  wire logic [7:0]       header_skip,
   output logic                  push,
   output lsp_pkg::rsp_type      rec
);

   localparam int BitW  = $clog2(SIZE_BITS + 1);
   localparam int ItemW = $clog2(EXT_CHARS + 1);
   localparam int RemW  = SIZE_BITS - 1;

   typedef enum logic [6:0] {
      PhSkip    = 7'b0000001,
      PhMagic   = 7'b0000010,
      PhExtSize = 7'b0000100,
      PhExt     = 7'b0001000,
      PhSize    = 7'b0010000,
      PhData    = 7'b0100000,
      PhDone    = 7'b1000000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [7:0]             skip_ff, skip_in;
   logic [BitW-1:0]        bitc_ff, bitc_in;
   logic [ItemW-1:0]       item_ff, item_in;
   logic [SIZE_BITS-1:0]   shf_ff, shf_in;
   logic [7:0]             mhold_ff, mhold_in;
   logic [RemW-1:0]        rem_ff, rem_in;

   always_comb begin
      logic [7:0]           ch;
      logic [SIZE_BITS-1:0] sz;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      bitc_in  = bitc_ff;
      item_in  = item_ff;
      shf_in   = shf_ff;
      mhold_in = mhold_ff;
      rem_in   = rem_ff;
      push     = 1'b0;
      rec      = '0;
      ch       = '0;
      sz       = '0;
      if (step) begin
         if (req.start_of_image) begin
            phase_in = PhSkip;
            skip_in  = '0;
            bitc_in  = '0;
            item_in  = '0;
            shf_in   = '0;
            mhold_in = '0;
            rem_in   = '0;
         end
         if (phase_in == PhSkip) begin
            if (skip_in < header_skip) begin
               skip_in = skip_in + 8'd1;
            end else begin
               phase_in = PhMagic;
               bitc_in  = '0;
               item_in  = '0;
               shf_in   = '0;
            end
         end
         if (phase_in != PhSkip && phase_in != PhDone) begin
            shf_in  = {shf_in[SIZE_BITS-2:0], req.cover_byte[0]};
            bitc_in = bitc_in + BitW'(1);
            ch      = shf_in[7:0];
            unique case (phase_in)
               PhMagic: begin
                  if (bitc_in == BitW'(8)) begin
                     bitc_in = '0;
                     if (item_in == '0) begin
                        mhold_in = ch;
                        item_in  = ItemW'(1);
                     end else begin
                        item_in = '0;
                        if ({mhold_in, ch} != magic_value) begin
                           phase_in = PhDone;
                           push     = 1'b1;
                           rec      = '{kind: lsp_pkg::KindMismatch, value: 8'd0, last: 1'b1};
                        end else begin
                           phase_in = PhExtSize;
                           shf_in   = '0;
                        end
                     end
                  end
               end
               PhExtSize: begin
                  if (bitc_in == BitW'(SIZE_BITS)) begin
                     bitc_in  = '0;
                     shf_in   = '0;
                     item_in  = '0;
                     phase_in = PhExt;
                  end
               end
               PhExt: begin
                  if (bitc_in == BitW'(8)) begin
                     bitc_in = '0;
                     item_in = item_in + ItemW'(1);
                     if (item_in >= ItemW'(EXT_CHARS)) begin
                        item_in  = '0;
                        shf_in   = '0;
                        phase_in = PhSize;
                     end
                     push = 1'b1;
                     rec  = '{kind: lsp_pkg::KindExt, value: ch, last: 1'b0};
                  end
               end
               PhSize: begin
                  if (bitc_in == BitW'(SIZE_BITS)) begin
                     bitc_in = '0;
                     sz      = shf_in;
                     shf_in  = '0;
                     if (sz == '0 || sz[SIZE_BITS-1]) begin
                        phase_in = PhDone;
                        push     = 1'b1;
                        rec      = '{kind: lsp_pkg::KindEmpty, value: 8'd0, last: 1'b1};
                     end else begin
                        rem_in   = sz[RemW-1:0];
                        phase_in = PhData;
                     end
                  end
               end
               PhData: begin
                  if (bitc_in == BitW'(8)) begin
                     bitc_in = '0;
                     rem_in  = rem_in - RemW'(1);
                     push    = 1'b1;
                     if (rem_in == '0) begin
                        phase_in = PhDone;
                        rec      = '{kind: lsp_pkg::KindPayload, value: ch, last: 1'b1};
                     end else begin
                        rec      = '{kind: lsp_pkg::KindPayload, value: ch, last: 1'b0};
                     end
                  end
               end
               default: begin
                  phase_in = PhDone;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhSkip;
         skip_ff  <= '0;
         bitc_ff  <= '0;
         item_ff  <= '0;
         shf_ff   <= '0;
         mhold_ff <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         bitc_ff  <= bitc_in;
         item_ff  <= item_in;
         shf_ff   <= shf_in;
         mhold_ff <= mhold_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lsp_queue.sv @@
`default_nettype none

module lsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lsp_pkg::rsp_type push_rec,
   output logic                  has_room,
   input  wire logic             pop,
   output logic                  head_valid,
   output lsp_pkg::rsp_type      head_rec
);

   localparam int PtrW = (lsp_pkg::QueueDepth > 1) ? $clog2(lsp_pkg::QueueDepth) : 1;
   localparam int CntW = $clog2(lsp_pkg::QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(lsp_pkg::QueueDepth - 1);

   lsp_pkg::rsp_type mem_ff [lsp_pkg::QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign has_room   = (count_ff != CntW'(lsp_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lsp_back.sv @@
`default_nettype none

module lsp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire lsp_pkg::rsp_type head_rec,
   output logic                  pop,
   output logic                  out_valid,
   output lsp_pkg::rsp_type      out_rec,
   input  wire logic             out_ready
);

   logic             valid_ff, valid_in;
   lsp_pkg::rsp_type rec_ff;

   assign pop       = head_valid && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lsb_stego_payload_extractor.sv @@
// Throughput: one request per cycle, sustained while the result side keeps up.
// A result goes from the parser into the queue, then into the output register, to rsp.
// The parser takes one hidden bit per request after the header skip, until its last result;
// a two-entry queue decouples it from rsp.
// Synchronous reset empties the queue and output, returns the parser to the header
// skip phase and loads the default magic value and header skip count.
`default_nettype none

module lsb_stego_payload_extractor #(
   parameter int EXT_CHARS = 4,
   parameter int SIZE_BITS = 32
) (
   input wire logic clock,
   input wire logic reset,
   lsp_chan_if.sink   req_chan,
   lsp_chan_if.source rsp_chan,
   lsp_chan_if.sink   csr_chan
);

   logic [15:0]      magic_ff;
   logic [7:0]       skip_ff;
   logic             step;
   logic             push;
   lsp_pkg::rsp_type push_rec;
   logic             has_room;
   logic             pop;
   logic             head_valid;
   lsp_pkg::rsp_type head_rec;
   lsp_pkg::req_type req_payload;
   lsp_pkg::csr_type csr_payload;
   lsp_pkg::rsp_type out_rec;
   logic             out_valid;

   assign req_payload    = req_chan.payload;
   assign csr_payload    = csr_chan.payload;
   assign req_chan.ready = has_room;
   assign step           = req_chan.valid && has_room;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= lsp_pkg::MagicReset;
         skip_ff  <= lsp_pkg::SkipReset;
      end else if (csr_chan.valid) begin
         unique case (csr_payload.index)
            lsp_pkg::CsrMagic: magic_ff <= csr_payload.data;
            lsp_pkg::CsrSkip:  skip_ff  <= csr_payload.data[7:0];
            default: begin
            end
         endcase
      end
   end

   lsp_front #(
      .EXT_CHARS(EXT_CHARS),
      .SIZE_BITS(SIZE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req        (req_payload),
      .magic_value(magic_ff),
      .header_skip(skip_ff),
      .push       (push),
      .rec        (push_rec)
   );

   lsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .has_room  (has_room),
      .pop       (pop),
      .head_valid(head_valid),
      .head_rec  (head_rec)
   );

   lsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_rec  (head_rec),
      .pop       (pop),
      .out_valid (out_valid),
      .out_rec   (out_rec),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.valid   = out_valid;
   assign rsp_chan.payload = out_rec;

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_rec.kind == lsp_pkg::KindMismatch ||
                    out_rec.kind == lsp_pkg::KindEmpty)
      |-> out_rec.last && out_rec.value == 8'd0)
      else $error("status result without last flag or with nonzero value");

   a_ext_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rec.kind == lsp_pkg::KindExt |-> !out_rec.last)
      else $error("extension character marked as last");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_valid)
      else $error("result valid right after reset");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> has_room)
      else $error("parser wrote a result into a full queue");

endmodule

`default_nettype wire
